/* hw/rtl/subsampling_auto_gain_ranger_assert.svh */
// Assertion macros for the auto-gain ranger.
// Included by the top level; its macros expand to nothing when SYNTH is set.
`ifndef SUBSAMPLING_AUTO_GAIN_RANGER_ASSERT_SVH
`define SUBSAMPLING_AUTO_GAIN_RANGER_ASSERT_SVH
`ifndef SYNTH
`define SAGR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("sagr assertion failed");
`define SAGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("sagr assertion failed");
`else
`define SAGR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SAGR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/sagr_pkg.sv */
// Shared types and constants for the auto-gain ranger.
// No dependencies.
`default_nettype none
package sagr_pkg;

	localparam int ALPHA_BITS = 16;
	localparam int SAMPLE_W   = 12;
	localparam int GAIN_W     = 3;
	localparam logic [GAIN_W-1:0] GAIN_LIMIT = 3'd6;

	typedef enum logic [2:0] {
		REG_SUBSAMPLE_FACTOR,
		REG_LEVEL_ALPHA,
		REG_VALUE_ALPHA,
		REG_HIGH_THRESHOLD,
		REG_LOW_THRESHOLD,
		REG_MAX_GAIN
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain;
		logic              changed;
	} gain_dec_t;

endpackage
`default_nettype wire

/* hw/rtl/sagr_ema.sv */
// Exponential mean update: acc + round(alpha * (x - acc) / 2^16).
// Uses sagr_pkg for the alpha width.
`default_nettype none
module sagr_ema #(
	parameter int ACC_W = 28
) (
	input  wire logic [ACC_W-1:0]                 acc,
	input  wire logic [ACC_W-1:0]                 x,
	input  wire logic [sagr_pkg::ALPHA_BITS-1:0]  alpha,
	output logic      [ACC_W-1:0]                 acc_next
);
	localparam int PW = ACC_W + sagr_pkg::ALPHA_BITS + 2;
	localparam logic [PW-1:0] ROUND = PW'(1) << (sagr_pkg::ALPHA_BITS - 1);

	logic signed [ACC_W:0]  diff;
	logic signed [PW-1:0]   prod;
	logic signed [PW-1:0]   step;

	// a*x + (2^16-a)*acc == 2^16*acc + a*(x-acc), so one signed multiply does it
	always_comb begin
		diff     = $signed({1'b0, x}) - $signed({1'b0, acc});
		prod     = diff * $signed({1'b0, alpha});
		step     = (prod + $signed(ROUND)) >>> sagr_pkg::ALPHA_BITS;
		acc_next = acc + step[ACC_W-1:0];
	end
endmodule
`default_nettype wire

/* hw/rtl/sagr_gain.sv */
// Gain ranging decision: compares the fresh level mean with the thresholds,
// steps the gain and halves or doubles the level mean. Uses sagr_pkg.
`default_nettype none
module sagr_gain #(
	parameter int FRAC_W = 16
) (
	input  wire logic [FRAC_W+sagr_pkg::SAMPLE_W-1:0] level,
	input  wire logic [sagr_pkg::GAIN_W-1:0]          gain_in,
	input  wire logic [sagr_pkg::SAMPLE_W-1:0]        high_thr,
	input  wire logic [sagr_pkg::SAMPLE_W-1:0]        low_thr,
	input  wire logic [sagr_pkg::GAIN_W-1:0]          max_gain,
	output logic      [FRAC_W+sagr_pkg::SAMPLE_W-1:0] level_out,
	output sagr_pkg::gain_dec_t                       dec
);
	localparam int ACC_W = FRAC_W + sagr_pkg::SAMPLE_W;
	localparam int GW    = sagr_pkg::GAIN_W;

	logic [ACC_W-1:0]            high_q16;
	logic [ACC_W-1:0]            low_q16;
	logic [sagr_pkg::GAIN_W-1:0] limit;

	always_comb begin
		high_q16  = {high_thr, {FRAC_W{1'b0}}};
		low_q16   = {low_thr, {FRAC_W{1'b0}}};
		limit     = (max_gain > sagr_pkg::GAIN_LIMIT) ? sagr_pkg::GAIN_LIMIT : max_gain;
		level_out = level;
		dec.gain    = gain_in;
		dec.changed = 1'b0;
		// high test wins when the thresholds cross
		if (level > high_q16) begin
			if (gain_in != '0) begin
				dec.gain    = gain_in - GW'(1);
				dec.changed = 1'b1;
				level_out   = level >> 1;
			end
		end else if (level < low_q16) begin
			if (gain_in < limit) begin
				dec.gain    = gain_in + GW'(1);
				dec.changed = 1'b1;
				// saturate on doubling
				level_out   = level[ACC_W-1] ? {ACC_W{1'b1}} : {level[ACC_W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

/* hw/rtl/subsampling_auto_gain_ranger.sv */
// Subsampling auto-gain ranger, top level.
// Uses sagr_pkg, sagr_ema, sagr_gain and subsampling_auto_gain_ranger_assert.svh.
//
// Usage:
//  - Samples enter on in_valid/in_ready with the 12-bit sample field. Every
//    subsample_factor-th sample (a factor of zero acts as one) produces one
//    result transaction on out_valid/out_ready; the others are absorbed.
//  - An accepted sample is held in the input register, where the count, both
//    mean updates and the gain decision are evaluated; a result is then
//    registered in the output register, which drives out_valid, and waits
//    there until out_ready takes it.
//  - Throughput is one sample per cycle while the output is not stalled; the
//    state feedback (count, gain, means) closes within the single compute stage.
//  - If the receiver stalls, the output register holds the result and one
//    more sample waits in the input register; in_ready falls only when that
//    sample would emit into a still-full output register.
//  - Reset clears count, gain and both means and loads the default register
//    values. Configuration writes (cfg_we, cfg_index, cfg_data) take effect at
//    the next edge and are meant for idle periods; unknown indexes are ignored.
`default_nettype none
`include "subsampling_auto_gain_ranger_assert.svh"
module subsampling_auto_gain_ranger #(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [11:0] sample,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [17:0]      scaled_sample,
	output logic [11:0]      level_mean,
	output logic [11:0]      value_mean,
	output logic [2:0]       gain_step,
	output logic             gain_changed
);
	localparam int SW    = sagr_pkg::SAMPLE_W;
	localparam int GW    = sagr_pkg::GAIN_W;
	localparam int ACC_W = FRACTION_BITS + SW;

	// configuration
	logic [15:0]   factor_q;
	logic [15:0]   level_alpha_q;
	logic [15:0]   value_alpha_q;
	logic [SW-1:0] high_thr_q;
	logic [SW-1:0] low_thr_q;
	logic [GW-1:0] max_gain_q;

	// state
	logic [15:0]    count_q;
	logic [GW-1:0]  gain_q;
	logic [ACC_W-1:0] level_q;
	logic [ACC_W-1:0] value_q;

	// input stage
	logic          valid_s1;
	logic [SW-1:0] sample_s1;

	// output register
	logic          out_valid_q;
	logic [17:0]   scaled_q;
	logic [SW-1:0] level_mean_q;
	logic [SW-1:0] value_mean_q;
	logic [GW-1:0] gain_step_q;
	logic          gain_changed_q;

	logic [16:0]      count_inc;
	logic             emit_s1;
	logic             adv;
	logic [17:0]      scaled6;
	logic [ACC_W-1:0] level_x;
	logic [ACC_W-1:0] value_x;
	logic [ACC_W-1:0] level_mix;
	logic [ACC_W-1:0] value_mix;
	logic [ACC_W-1:0] level_adj;
	sagr_pkg::gain_dec_t dec;

	always_comb begin
		count_inc = {1'b0, count_q} + 17'd1;
		emit_s1   = !(count_inc < {1'b0, factor_q});
		adv       = valid_s1 && (!emit_s1 || !out_valid_q || out_ready);
		in_ready  = !valid_s1 || adv;
		scaled6   = {sample_s1, 6'b0} >> gain_q;
		level_x   = {sample_s1, {FRACTION_BITS{1'b0}}};
		value_x   = level_x >> gain_q;
	end

	sagr_ema #(.ACC_W(ACC_W)) u_level_ema (
		.acc      (level_q),
		.x        (level_x),
		.alpha    (level_alpha_q),
		.acc_next (level_mix)
	);

	sagr_ema #(.ACC_W(ACC_W)) u_value_ema (
		.acc      (value_q),
		.x        (value_x),
		.alpha    (value_alpha_q),
		.acc_next (value_mix)
	);

	sagr_gain #(.FRAC_W(FRACTION_BITS)) u_gain (
		.level     (level_mix),
		.gain_in   (gain_q),
		.high_thr  (high_thr_q),
		.low_thr   (low_thr_q),
		.max_gain  (max_gain_q),
		.level_out (level_adj),
		.dec       (dec)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q      <= 16'd6;
			level_alpha_q <= 16'd66;
			value_alpha_q <= 16'd655;
			high_thr_q    <= 12'd2730;
			low_thr_q     <= 12'd1365;
			max_gain_q    <= 3'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sagr_pkg::REG_SUBSAMPLE_FACTOR: factor_q      <= cfg_data;
				sagr_pkg::REG_LEVEL_ALPHA:      level_alpha_q <= cfg_data;
				sagr_pkg::REG_VALUE_ALPHA:      value_alpha_q <= cfg_data;
				sagr_pkg::REG_HIGH_THRESHOLD:   high_thr_q    <= cfg_data[SW-1:0];
				sagr_pkg::REG_LOW_THRESHOLD:    low_thr_q     <= cfg_data[SW-1:0];
				sagr_pkg::REG_MAX_GAIN:         max_gain_q    <= cfg_data[GW-1:0];
				default: ;
			endcase
		end
	end

	// control and state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			gain_q      <= '0;
			level_q     <= '0;
			value_q     <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv && emit_s1) begin
				out_valid_q <= 1'b1;
				count_q     <= '0;
				gain_q      <= dec.gain;
				level_q     <= level_adj;
				value_q     <= value_mix;
			end else begin
				if (out_ready)
					out_valid_q <= 1'b0;
				if (adv)
					count_q <= count_inc[15:0];
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			sample_s1 <= sample;
		if (adv && emit_s1) begin
			scaled_q       <= scaled6;
			level_mean_q   <= level_adj[ACC_W-1:FRACTION_BITS];
			value_mean_q   <= value_mix[ACC_W-1:FRACTION_BITS];
			gain_step_q    <= dec.gain;
			gain_changed_q <= dec.changed;
		end
	end

	assign out_valid     = out_valid_q;
	assign scaled_sample = scaled_q;
	assign level_mean    = level_mean_q;
	assign value_mean    = value_mean_q;
	assign gain_step     = gain_step_q;
	assign gain_changed  = gain_changed_q;

	`SAGR_ASSERT_IMPL(a_out_gain_match, clk, arst_n, out_valid_q, gain_step_q == gain_q)
	`SAGR_ASSERT_NEXT(a_gain_hold, clk, arst_n, !(adv && emit_s1), gain_q == $past(gain_q))
	`SAGR_ASSERT_IMPL(a_gain_limit, clk, arst_n, 1'b1, gain_q <= sagr_pkg::GAIN_LIMIT)
	`SAGR_ASSERT_NEXT(a_count_clear, clk, arst_n, adv && emit_s1, count_q == '0)
endmodule
`default_nettype wire

/* dv/subsampling_auto_gain_ranger_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for subsampling_auto_gain_ranger: a directed table, then randomised
// configuration phases, every result checked against a cycle-free predictor of the ranger.
// Depends on sagr_pkg and the ranger RTL only.
module subsampling_auto_gain_ranger_tb;

	localparam int FRAC          = 16;
	localparam int IDLE_PCT      = 11;
	localparam int STALL_LIMIT   = 1000;
	localparam int PHASES        = 14;
	localparam int PHASE_ITEMS   = 113;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 10;
	localparam logic [63:0] LEVEL_CEIL = (64'd4096 << FRAC) - 64'd1;

	typedef struct packed {
		logic [17:0] scaled_q6;
		logic [11:0] lvl_mean;
		logic [11:0] val_mean;
		logic [2:0]  gain;
		logic        changed;
	} range_result_t;

	typedef enum bit {ROW_SAMPLE, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t          kind;
		sagr_pkg::reg_idx_t idx;
		logic [15:0]        data;
		logic               pinned;
		range_result_t      res;
	} dir_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	sagr_pkg::reg_idx_t cfg_index = sagr_pkg::REG_SUBSAMPLE_FACTOR;
	logic [15:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [11:0]        sample = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [17:0]        scaled_sample;
	logic [11:0]        level_mean;
	logic [11:0]        value_mean;
	logic [2:0]         gain_step;
	logic               gain_changed;

	// register mirror and ranger state
	logic [15:0]   factor_r, lvl_alpha_r, val_alpha_r;
	logic [11:0]   hi_thr_r, lo_thr_r;
	logic [2:0]    max_gain_r, gain_r;
	logic [15:0]   count_r;
	logic [63:0]   lvl_acc, val_acc;

	range_result_t pending_results [$];
	logic          pin_on = 1'b0;
	range_result_t pin_res = '0;
	bit            no_gaps = 1'b0;
	int            errors = 0;
	int            items_in = 0;
	int            results_seen = 0;
	int            gain_moves = 0;
	int            stall_cycles = 0;

	subsampling_auto_gain_ranger u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.scaled_sample(scaled_sample),
		.level_mean   (level_mean),
		.value_mean   (value_mean),
		.gain_step    (gain_step),
		.gain_changed (gain_changed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// exponential mean step, alpha in Q0.16, rounds half up
	function automatic logic [63:0] ema_mix(input logic [63:0] acc, input logic [63:0] x,
			input logic [15:0] alpha);
		logic [63:0] a;
		a = {48'd0, alpha};
		return (a * x + (64'd65536 - a) * acc + 64'd32768) >> sagr_pkg::ALPHA_BITS;
	endfunction

	function automatic bit range_sample(input logic [11:0] s, output range_result_t r);
		logic [2:0]  g;
		logic [2:0]  lim;
		logic [63:0] xq;
		r = '0;
		g = (gain_r > sagr_pkg::GAIN_LIMIT) ? sagr_pkg::GAIN_LIMIT : gain_r;
		if ({16'd0, count_r} + 32'd1 < {16'd0, factor_r}) begin
			count_r = count_r + 16'd1;
			return 1'b0;
		end
		count_r = '0;
		xq = {52'd0, s} << FRAC;
		r.scaled_q6 = {s, 6'd0} >> g;
		lvl_acc = ema_mix(lvl_acc, xq, lvl_alpha_r);
		val_acc = ema_mix(val_acc, xq >> g, val_alpha_r);
		lim = (max_gain_r > sagr_pkg::GAIN_LIMIT) ? sagr_pkg::GAIN_LIMIT : max_gain_r;
		// high test wins when the thresholds cross
		if (lvl_acc > ({52'd0, hi_thr_r} << FRAC)) begin
			if (g != 3'd0) begin
				g = g - 3'd1;
				lvl_acc = lvl_acc >> 1;
				r.changed = 1'b1;
			end
		end else if (lvl_acc < ({52'd0, lo_thr_r} << FRAC)) begin
			if (g < lim) begin
				g = g + 3'd1;
				lvl_acc = lvl_acc << 1;
				if (lvl_acc > LEVEL_CEIL)
					lvl_acc = LEVEL_CEIL;
				r.changed = 1'b1;
			end
		end
		gain_r = g;
		r.lvl_mean = lvl_acc[FRAC +: 12];
		r.val_mean = val_acc[FRAC +: 12];
		r.gain = g;
		return 1'b1;
	endfunction

	task automatic check_field(input string what, input logic [17:0] want, input logic [17:0] got);
		if (want !== got) begin
			errors++;
			$display("%t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk) begin : monitor
		range_result_t predicted;
		range_result_t want;
		bit            emits;
		bit            moved;
		if (!arst_n) begin
			factor_r    = 16'd6;
			lvl_alpha_r = 16'd66;
			val_alpha_r = 16'd655;
			hi_thr_r    = 12'd2730;
			lo_thr_r    = 12'd1365;
			max_gain_r  = 3'd6;
			count_r     = '0;
			gain_r      = '0;
			lvl_acc     = '0;
			val_acc     = '0;
		end else begin
			moved = 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					sagr_pkg::REG_SUBSAMPLE_FACTOR: factor_r    = cfg_data;
					sagr_pkg::REG_LEVEL_ALPHA:      lvl_alpha_r = cfg_data;
					sagr_pkg::REG_VALUE_ALPHA:      val_alpha_r = cfg_data;
					sagr_pkg::REG_HIGH_THRESHOLD:   hi_thr_r    = cfg_data[11:0];
					sagr_pkg::REG_LOW_THRESHOLD:    lo_thr_r    = cfg_data[11:0];
					sagr_pkg::REG_MAX_GAIN:         max_gain_r  = cfg_data[2:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				items_in++;
				emits = range_sample(sample, predicted);
				want = pin_on ? pin_res : predicted;
				if (pin_on && !emits) begin
					errors++;
					$display("%t: table row expects a result but sample %0d is absorbed",
						$time, sample);
				end else if (emits) begin
					pending_results.insert(pending_results.size(), want);
				end
			end
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					errors++;
					$display("%t: unexpected result transaction: scaled %0d level %0d value %0d",
						$time, scaled_sample, level_mean, value_mean);
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					check_field("scaled_sample", want.scaled_q6, scaled_sample);
					check_field("level_mean", 18'(want.lvl_mean), 18'(level_mean));
					check_field("value_mean", 18'(want.val_mean), 18'(value_mean));
					check_field("gain_step", 18'(want.gain), 18'(gain_step));
					check_field("gain_changed", 18'(want.changed), 18'(gain_changed));
					results_seen++;
					if (gain_changed)
						gain_moves++;
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// hold off until every pending result is out and any absorbed sample has settled
	task automatic quiesce();
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input sagr_pkg::reg_idx_t idx, input logic [15:0] v);
		quiesce();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic push_sample(input logic [11:0] s);
		while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic dir_row_t smp(input logic [11:0] s);
		dir_row_t row;
		row = '0;
		row.kind = ROW_SAMPLE;
		row.data = {4'd0, s};
		return row;
	endfunction

	function automatic dir_row_t smp_pin(input logic [11:0] s, input range_result_t res);
		dir_row_t row;
		row = smp(s);
		row.pinned = 1'b1;
		row.res = res;
		return row;
	endfunction

	function automatic dir_row_t reg_row(input sagr_pkg::reg_idx_t idx, input logic [15:0] v);
		dir_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.idx = idx;
		row.data = v;
		return row;
	endfunction

	function automatic logic [15:0] pick_alpha();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'd1;
			2, 3:    return 16'hFFFF;
			4, 5, 6: return 16'($urandom_range(4096, 65535));
			default: return 16'($urandom_range(1, 4095));
		endcase
	endfunction

	function automatic logic [15:0] pick_factor();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			6, 7:    return 16'($urandom_range(2, 4));
			8:       return 16'($urandom_range(5, 12));
			default: return 16'd1;
		endcase
	endfunction

	initial begin : stimulus
		dir_row_t    dir_rows [$];
		int          base;
		int          spread;
		int          near;
		logic [11:0] s;
		logic [11:0] hi;
		logic [11:0] lo;
		dir_rows = '{
			smp(12'd4095), smp(12'd0), smp(12'd4095), smp(12'd1), smp(12'd2048),
			// sixth sample after reset emits; an empty mean raises the gain
			smp_pin(12'd0, '{18'd0, 12'd0, 12'd0, 3'd1, 1'b1}),
			reg_row(sagr_pkg::REG_SUBSAMPLE_FACTOR, 16'd1),
			reg_row(sagr_pkg::REG_LEVEL_ALPHA, 16'd0),
			reg_row(sagr_pkg::REG_VALUE_ALPHA, 16'd0),
			// frozen means: gain climbs to the top step and stops there
			smp_pin(12'd4095, '{18'd131040, 12'd0, 12'd0, 3'd2, 1'b1}),
			smp_pin(12'd4095, '{18'd65520, 12'd0, 12'd0, 3'd3, 1'b1}),
			smp_pin(12'd4095, '{18'd32760, 12'd0, 12'd0, 3'd4, 1'b1}),
			smp_pin(12'd4095, '{18'd16380, 12'd0, 12'd0, 3'd5, 1'b1}),
			smp_pin(12'd4095, '{18'd8190, 12'd0, 12'd0, 3'd6, 1'b1}),
			smp_pin(12'd4095, '{18'd4095, 12'd0, 12'd0, 3'd6, 1'b0}),
			reg_row(sagr_pkg::REG_MAX_GAIN, 16'd7),
			smp_pin(12'd4095, '{18'd4095, 12'd0, 12'd0, 3'd6, 1'b0}),
			// gain already above the new ceiling: no step up
			reg_row(sagr_pkg::REG_MAX_GAIN, 16'd2),
			smp_pin(12'd0, '{18'd0, 12'd0, 12'd0, 3'd6, 1'b0}),
			reg_row(sagr_pkg::REG_LEVEL_ALPHA, 16'hFFFF),
			smp_pin(12'd4095, '{18'd4095, 12'd2047, 12'd0, 3'd5, 1'b1}),
			// crossed thresholds
			reg_row(sagr_pkg::REG_HIGH_THRESHOLD, 16'd0),
			reg_row(sagr_pkg::REG_LOW_THRESHOLD, 16'd4095),
			smp(12'd2048),
			reg_row(sagr_pkg::REG_VALUE_ALPHA, 16'hFFFF),
			reg_row(sagr_pkg::REG_SUBSAMPLE_FACTOR, 16'd0),
			smp(12'd4095), smp(12'd0),
			// count builds up under a huge factor, then a lower factor emits at once
			reg_row(sagr_pkg::REG_SUBSAMPLE_FACTOR, 16'hFFFF),
			smp(12'd100), smp(12'd3000), smp(12'd4095),
			reg_row(sagr_pkg::REG_SUBSAMPLE_FACTOR, 16'd2),
			smp(12'd7),
			reg_row(sagr_pkg::REG_HIGH_THRESHOLD, 16'd4095),
			reg_row(sagr_pkg::REG_LOW_THRESHOLD, 16'd0),
			smp(12'd4095), smp(12'd0)
		};

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				pin_on = dir_rows[i].pinned;
				pin_res = dir_rows[i].res;
				push_sample(dir_rows[i].data[11:0]);
				pin_on = 1'b0;
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			// one phase runs flat out on both sides
			no_gaps = (ph == 5);
			case ($urandom_range(0, 9))
				0: begin
					hi = 12'($urandom_range(0, 4095));
					lo = 12'($urandom_range(0, 4095));
				end
				1: begin
					hi = 12'hFFF;
					lo = 12'h000;
				end
				default: begin
					hi = 12'($urandom_range(2048, 4095));
					lo = 12'($urandom_range(0, 2047));
				end
			endcase
			write_reg(sagr_pkg::REG_SUBSAMPLE_FACTOR, pick_factor());
			write_reg(sagr_pkg::REG_LEVEL_ALPHA, pick_alpha());
			write_reg(sagr_pkg::REG_VALUE_ALPHA, pick_alpha());
			write_reg(sagr_pkg::REG_HIGH_THRESHOLD, {4'd0, hi});
			write_reg(sagr_pkg::REG_LOW_THRESHOLD, {4'd0, lo});
			write_reg(sagr_pkg::REG_MAX_GAIN, 16'($urandom_range(0, 7)));
			base = int'($urandom_range(0, 4095));
			spread = int'($urandom_range(0, 600));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 9 && n == PHASE_ITEMS / 2)
					quiesce();
				case ($urandom_range(0, 9))
					0: s = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
					1, 2, 3, 4: begin
						near = base + int'($urandom_range(0, 2 * spread)) - spread;
						if (near < 0)
							near = 0;
						if (near > 4095)
							near = 4095;
						s = 12'(near);
					end
					default: s = 12'($urandom);
				endcase
				push_sample(s);
			end
		end

		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_results.size() != 0) begin
			errors++;
			$display("%t: %0d results never arrived", $time, pending_results.size());
		end

		$display("Run: %0d samples in, %0d results checked, %0d gain steps, %0d random phases.",
			items_in, results_seen, gain_moves, PHASES);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
